>>> rtl/tbi_pkg.sv
// Shared types, codes and defaults of the bilinear table interpolator.
package tbi_pkg;

	localparam int DEF_MAX_X_BINS = 16;
	localparam int DEF_MAX_Y_BINS = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W = 5;
	localparam int WIDE_CNT_W = 9;

	typedef enum logic [1:0] {
		ACT_LOAD_X = 2'd0,
		ACT_LOAD_Y = 2'd1,
		ACT_LOAD_CELL = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	localparam logic [2:0] REGION_INTERIOR = 3'd0;
	localparam logic [2:0] REGION_BOTH_BELOW = 3'd1;
	localparam logic [2:0] REGION_X_BELOW = 3'd2;
	localparam logic [2:0] REGION_Y_BELOW = 3'd3;
	localparam logic [2:0] REGION_TOP = 3'd4;

	localparam logic CFG_X_COUNT = 1'b0;
	localparam logic CFG_Y_COUNT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XRD,
		ST_XCMP,
		ST_YRD,
		ST_YCMP,
		ST_CRD,
		ST_CCAP,
		ST_LGO,
		ST_LWAIT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		LP_IDLE,
		LP_MUL,
		LP_DIV,
		LP_DONE
	} lerp_phase_t;

	typedef struct packed {
		logic load;
		logic start;
		logic x_cmp;
		logic y_cmp;
		logic c_cap;
		logic l_go;
		logic l_cap;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic x_done;
		logic y_done;
		logic c_last;
		logic interior;
		logic l_done;
		logic l_last;
	} dp_stat_t;

endpackage

>>> rtl/tbi_if.sv
// Valid/ready channel interfaces for request and response beats.
interface tbi_req_if;
	import tbi_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [3:0] row;
	logic [3:0] col;
	logic signed [DATA_W-1:0] load_value;
	logic signed [DATA_W-1:0] query_x;
	logic signed [DATA_W-1:0] query_y;
	modport source (output valid, action, row, col, load_value, query_x, query_y, input ready);
	modport sink (input valid, action, row, col, load_value, query_x, query_y, output ready);
endinterface

interface tbi_rsp_if;
	import tbi_pkg::*;
	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] result;
	logic [2:0] region;
	modport source (output valid, result, region, input ready);
	modport sink (input valid, result, region, output ready);
endinterface

>>> rtl/table_bilinear_interpolate_2d.sv
// Top level of the two-dimensional bilinear lookup table.
// Usage:
//   req carries beats of action, row, col, load_value, query_x and query_y.
//   Load beats (x breakpoint, y breakpoint, grid cell) are written in the
//   cycle they are accepted and give no response; req.ready stays high.
//   A query beat gives one rsp beat with result and region.
//   A query walks linearly through the x and then the y breakpoint RAMs,
//   reads one grid cell for edge regions or four for the interior, and for
//   the interior runs three interpolations on the shared multiply/divide
//   unit (bit-serial division) before loading the response register.
//   req.ready is low during a query.
//   Reset clears the controller and sets x_count and y_count to 16; the
//   tables are undefined until written and have no clearing pass.
//   A stalled rsp holds its beat; loads are still taken while it waits,
//   and a following query finishes its work and holds until the beat drains.
//   cfg_we writes cfg_data into the count chosen by cfg_index. The user
//   must write it only while idle; the block itself does not enforce this.
module table_bilinear_interpolate_2d #(
	parameter int MAX_X_BINS = tbi_pkg::DEF_MAX_X_BINS,
	parameter int MAX_Y_BINS = tbi_pkg::DEF_MAX_Y_BINS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	tbi_req_if.sink                   req,
	tbi_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [tbi_pkg::CNT_W-1:0] cfg_data
);
	import tbi_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	tbi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_action(req.action), .req_ready(req.ready),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.cmd(cmd), .stat(stat)
	);

	tbi_dp #(.MAX_X_BINS(MAX_X_BINS), .MAX_Y_BINS(MAX_Y_BINS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.action(req.action), .row(req.row), .col(req.col),
		.load_value(req.load_value), .query_x(req.query_x), .query_y(req.query_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result(rsp.result), .region(rsp.region)
	);
endmodule

>>> rtl/tbi_ram.sv
// Generic one-write one-read RAM with registered read data.
module tbi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/tbi_lerp.sv
// Lerp unit: one multiply, then a bit-serial rounded divide if p1 < p < p2.
module tbi_lerp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [tbi_pkg::DATA_W-1:0] p1,
	input  logic signed [tbi_pkg::DATA_W-1:0] v1,
	input  logic signed [tbi_pkg::DATA_W-1:0] p2,
	input  logic signed [tbi_pkg::DATA_W-1:0] v2,
	input  logic signed [tbi_pkg::DATA_W-1:0] p,
	output logic                          done,
	output logic signed [tbi_pkg::DATA_W-1:0] y
);
	import tbi_pkg::*;

	lerp_phase_t phase_q;
	logic [4:0] cnt_q;
	logic quick_q;
	logic signed [DATA_W-1:0] quick_val_q;
	logic signed [DATA_W-1:0] v1_q;
	logic neg_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] dp_q;
	logic [DATA_W-1:0] dvmag_q;
	logic [DATA_W:0] rem_q;
	logic [DATA_W-1:0] low_q;

	logic signed [DATA_W:0] den_w, dp_w, dv_w;
	logic [DATA_W:0] dvabs_w;
	logic [2*DATA_W-1:0] mag_w;
	logic [2*DATA_W:0] num_w;
	logic [DATA_W+1:0] rem_sh_w;
	logic ge_w;

	assign den_w = {p2[DATA_W-1], p2} - {p1[DATA_W-1], p1};
	assign dp_w = {p[DATA_W-1], p} - {p1[DATA_W-1], p1};
	assign dv_w = {v2[DATA_W-1], v2} - {v1[DATA_W-1], v1};
	assign dvabs_w = dv_w[DATA_W] ? (DATA_W+1)'(-dv_w) : dv_w;
	assign mag_w = dvmag_q * dp_q;
	assign num_w = {1'b0, mag_w} + (2*DATA_W+1)'(den_q >> 1);
	assign rem_sh_w = {rem_q, low_q[DATA_W-1]};
	assign ge_w = rem_sh_w >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= LP_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (phase_q)
				LP_IDLE: if (start) begin
					phase_q <= LP_MUL;
				end
				LP_MUL: begin
					phase_q <= quick_q ? LP_DONE : LP_DIV;
					cnt_q <= '0;
				end
				LP_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						phase_q <= LP_DONE;
					end
				end
				LP_DONE: phase_q <= LP_IDLE;
				default: phase_q <= LP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == LP_IDLE && start) begin
			v1_q <= v1;
			neg_q <= dv_w[DATA_W];
			dvmag_q <= dvabs_w[DATA_W-1:0];
			den_q <= den_w[DATA_W-1:0];
			dp_q <= dp_w[DATA_W-1:0];
			if (den_w[DATA_W] || den_w == '0 || dp_w[DATA_W] || dp_w == '0) begin
				quick_q <= 1'b1;
				quick_val_q <= v1;
			end else if (dp_w >= den_w) begin
				quick_q <= 1'b1;
				quick_val_q <= v2;
			end else begin
				quick_q <= 1'b0;
				quick_val_q <= v1;
			end
		end
		if (phase_q == LP_MUL) begin
			rem_q <= num_w[2*DATA_W:DATA_W];
			low_q <= num_w[DATA_W-1:0];
		end
		if (phase_q == LP_DIV) begin
			rem_q <= ge_w ? (DATA_W+1)'(rem_sh_w - {2'b00, den_q}) : rem_sh_w[DATA_W:0];
			low_q <= {low_q[DATA_W-2:0], ge_w};
		end
	end

	assign done = (phase_q == LP_DONE);
	assign y = quick_q ? quick_val_q : (neg_q ? v1_q - $signed(low_q) : v1_q + $signed(low_q));
endmodule

>>> rtl/tbi_dp.sv
// Datapath: tables, breakpoint search registers, cell fetch and output register.
module tbi_dp #(
	parameter int MAX_X_BINS = tbi_pkg::DEF_MAX_X_BINS,
	parameter int MAX_Y_BINS = tbi_pkg::DEF_MAX_Y_BINS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tbi_pkg::dp_cmd_t                  cmd,
	output tbi_pkg::dp_stat_t                 stat,
	input  logic [1:0]                        action,
	input  logic [3:0]                        row,
	input  logic [3:0]                        col,
	input  logic signed [tbi_pkg::DATA_W-1:0] load_value,
	input  logic signed [tbi_pkg::DATA_W-1:0] query_x,
	input  logic signed [tbi_pkg::DATA_W-1:0] query_y,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [tbi_pkg::CNT_W-1:0]         cfg_data,
	output logic signed [tbi_pkg::DATA_W-1:0] result,
	output logic [2:0]                        region
);
	import tbi_pkg::*;

	localparam int XW = $clog2(MAX_X_BINS);
	localparam int YW = $clog2(MAX_Y_BINS);
	localparam int GD = MAX_X_BINS * MAX_Y_BINS;
	localparam int GW = $clog2(GD);

	logic [CNT_W-1:0] x_count_q, y_count_q;
	logic [WIDE_CNT_W-1:0] xc_w, yc_w, nx_w, ny_w;
	logic [XW-1:0] xlast_w;
	logic [YW-1:0] ylast_w;

	logic signed [DATA_W-1:0] qx_q, qy_q;
	logic [XW-1:0] xptr_q, xi_q;
	logic [YW-1:0] yptr_q, yi_q;
	logic xbelow_q, ybelow_q;
	logic signed [DATA_W-1:0] x1_q, x2_q, y1_q, y2_q;
	logic [1:0] cidx_q, lsel_q;
	logic signed [DATA_W-1:0] c_q [4];
	logic signed [DATA_W-1:0] lo_q, hi_q, res_q;

	logic xw_en, yw_en, gw_en;
	logic [GW-1:0] gwaddr_w, graddr_w;
	logic signed [DATA_W-1:0] xd_w, yd_w, gd_w;
	logic [XW-1:0] cr_w;
	logic [YW-1:0] cc_w;
	logic [2:0] region_w;
	logic xedge_w, yedge_w;
	logic signed [DATA_W-1:0] lp1, lv1, lp2, lv2, lp, ly;
	logic l_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_count_q <= CNT_W'(16);
			y_count_q <= CNT_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_COUNT: x_count_q <= cfg_data;
				CFG_Y_COUNT: y_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign xc_w = WIDE_CNT_W'(x_count_q);
	assign yc_w = WIDE_CNT_W'(y_count_q);
	assign nx_w = (xc_w < WIDE_CNT_W'(2)) ? WIDE_CNT_W'(2) :
		(xc_w > WIDE_CNT_W'(MAX_X_BINS)) ? WIDE_CNT_W'(MAX_X_BINS) : xc_w;
	assign ny_w = (yc_w < WIDE_CNT_W'(2)) ? WIDE_CNT_W'(2) :
		(yc_w > WIDE_CNT_W'(MAX_Y_BINS)) ? WIDE_CNT_W'(MAX_Y_BINS) : yc_w;
	assign xlast_w = XW'(nx_w - WIDE_CNT_W'(1));
	assign ylast_w = YW'(ny_w - WIDE_CNT_W'(1));

	assign xw_en = cmd.load && action == ACT_LOAD_X &&
		WIDE_CNT_W'(row) < WIDE_CNT_W'(MAX_X_BINS);
	assign yw_en = cmd.load && action == ACT_LOAD_Y &&
		WIDE_CNT_W'(col) < WIDE_CNT_W'(MAX_Y_BINS);
	assign gw_en = cmd.load && action == ACT_LOAD_CELL &&
		WIDE_CNT_W'(row) < WIDE_CNT_W'(MAX_X_BINS) &&
		WIDE_CNT_W'(col) < WIDE_CNT_W'(MAX_Y_BINS);
	assign gwaddr_w = GW'(row) * GW'(MAX_Y_BINS) + GW'(col);

	tbi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_X_BINS)) u_xbp (
		.clk(clk), .we(xw_en), .waddr(XW'(row)), .wdata(load_value),
		.raddr(xptr_q), .rdata(xd_w)
	);
	tbi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_Y_BINS)) u_ybp (
		.clk(clk), .we(yw_en), .waddr(YW'(col)), .wdata(load_value),
		.raddr(yptr_q), .rdata(yd_w)
	);
	tbi_ram #(.WIDTH(DATA_W), .DEPTH(GD)) u_grid (
		.clk(clk), .we(gw_en), .waddr(gwaddr_w), .wdata(load_value),
		.raddr(graddr_w), .rdata(gd_w)
	);

	// breakpoint walk: first beat checks below-range, then climbs while bp <= q
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q <= query_x;
			qy_q <= query_y;
			xptr_q <= '0;
			yptr_q <= '0;
			xi_q <= '0;
			yi_q <= '0;
			xbelow_q <= 1'b0;
			ybelow_q <= 1'b0;
			cidx_q <= '0;
			lsel_q <= '0;
		end
		if (cmd.x_cmp) begin
			if (xptr_q == '0) begin
				if (qx_q < xd_w) begin
					xbelow_q <= 1'b1;
				end else begin
					x1_q <= xd_w;
					xptr_q <= XW'(1);
				end
			end else if (xd_w <= qx_q) begin
				xi_q <= xptr_q;
				x1_q <= xd_w;
				if (xptr_q != xlast_w) begin
					xptr_q <= xptr_q + XW'(1);
				end
			end else begin
				x2_q <= xd_w;
			end
		end
		if (cmd.y_cmp) begin
			if (yptr_q == '0) begin
				if (qy_q < yd_w) begin
					ybelow_q <= 1'b1;
				end else begin
					y1_q <= yd_w;
					yptr_q <= YW'(1);
				end
			end else if (yd_w <= qy_q) begin
				yi_q <= yptr_q;
				y1_q <= yd_w;
				if (yptr_q != ylast_w) begin
					yptr_q <= yptr_q + YW'(1);
				end
			end else begin
				y2_q <= yd_w;
			end
		end
		if (cmd.c_cap) begin
			c_q[cidx_q] <= gd_w;
			cidx_q <= cidx_q + 2'd1;
		end
		if (cmd.l_cap) begin
			unique case (lsel_q)
				2'd0: lo_q <= ly;
				2'd1: hi_q <= ly;
				default: res_q <= ly;
			endcase
			lsel_q <= lsel_q + 2'd1;
		end
		if (cmd.out_load) begin
			result <= (region_w == REGION_INTERIOR) ? res_q : c_q[0];
			region <= region_w;
		end
	end

	assign xedge_w = (xi_q == xlast_w);
	assign yedge_w = (yi_q == ylast_w);

	always_comb begin
		priority if (xbelow_q && ybelow_q) begin
			region_w = REGION_BOTH_BELOW;
		end else if (xbelow_q) begin
			region_w = REGION_X_BELOW;
		end else if (ybelow_q) begin
			region_w = REGION_Y_BELOW;
		end else if (xedge_w || yedge_w) begin
			region_w = REGION_TOP;
		end else begin
			region_w = REGION_INTERIOR;
		end
	end

	always_comb begin
		unique case (region_w)
			REGION_BOTH_BELOW: begin
				cr_w = '0;
				cc_w = '0;
			end
			REGION_X_BELOW: begin
				cr_w = '0;
				cc_w = yi_q;
			end
			REGION_Y_BELOW: begin
				cr_w = xi_q;
				cc_w = '0;
			end
			REGION_TOP: begin
				cr_w = xlast_w;
				cc_w = ylast_w;
			end
			default: begin
				cr_w = xi_q + XW'(cidx_q[0]);
				cc_w = yi_q + YW'(cidx_q[1]);
			end
		endcase
	end

	assign graddr_w = GW'(cr_w) * GW'(MAX_Y_BINS) + GW'(cc_w);

	always_comb begin
		unique case (lsel_q)
			2'd0: begin
				lp1 = x1_q; lv1 = c_q[0]; lp2 = x2_q; lv2 = c_q[1]; lp = qx_q;
			end
			2'd1: begin
				lp1 = x1_q; lv1 = c_q[2]; lp2 = x2_q; lv2 = c_q[3]; lp = qx_q;
			end
			default: begin
				lp1 = y1_q; lv1 = lo_q; lp2 = y2_q; lv2 = hi_q; lp = qy_q;
			end
		endcase
	end

	tbi_lerp u_lerp (
		.clk(clk), .arst_n(arst_n), .start(cmd.l_go),
		.p1(lp1), .v1(lv1), .p2(lp2), .v2(lv2), .p(lp),
		.done(l_done), .y(ly)
	);

	always_comb begin
		stat.x_done = (xptr_q == '0) ? (qx_q < xd_w) : (!(xd_w <= qx_q) || xptr_q == xlast_w);
		stat.y_done = (yptr_q == '0) ? (qy_q < yd_w) : (!(yd_w <= qy_q) || yptr_q == ylast_w);
		stat.interior = (region_w == REGION_INTERIOR);
		stat.c_last = stat.interior ? (cidx_q == 2'd3) : (cidx_q == 2'd0);
		stat.l_done = l_done;
		stat.l_last = (lsel_q == 2'd2);
	end
endmodule

>>> rtl/tbi_ctrl.sv
// Controller: sequences search, cell fetch, interpolation and the response beat.
module tbi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_action,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tbi_pkg::dp_cmd_t  cmd,
	input  tbi_pkg::dp_stat_t stat
);
	import tbi_pkg::*;

	state_t state_q, state_d;
	logic ovq;
	logic fire;

	assign req_ready = (state_q == ST_IDLE);
	assign fire = req_valid && req_ready;
	assign rsp_valid = ovq;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (fire && req_action == ACT_QUERY) begin
				state_d = ST_XRD;
			end
			ST_XRD: state_d = ST_XCMP;
			ST_XCMP: state_d = stat.x_done ? ST_YRD : ST_XRD;
			ST_YRD: state_d = ST_YCMP;
			ST_YCMP: state_d = stat.y_done ? ST_CRD : ST_YRD;
			ST_CRD: state_d = ST_CCAP;
			ST_CCAP: begin
				if (stat.c_last) begin
					state_d = stat.interior ? ST_LGO : ST_OUT;
				end else begin
					state_d = ST_CRD;
				end
			end
			ST_LGO: state_d = ST_LWAIT;
			ST_LWAIT: if (stat.l_done) begin
				state_d = stat.l_last ? ST_OUT : ST_LGO;
			end
			ST_OUT: if (!ovq || rsp_ready) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = fire && req_action != ACT_QUERY;
				cmd.start = fire && req_action == ACT_QUERY;
			end
			ST_XCMP: cmd.x_cmp = 1'b1;
			ST_YCMP: cmd.y_cmp = 1'b1;
			ST_CCAP: cmd.c_cap = 1'b1;
			ST_LGO: cmd.l_go = 1'b1;
			ST_LWAIT: cmd.l_cap = stat.l_done;
			ST_OUT: cmd.out_load = !ovq || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovq <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				ovq <= 1'b1;
			end else if (rsp_ready) begin
				ovq <= 1'b0;
			end
		end
	end

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp_valid) else $error("response beat not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !cmd.out_load) else $error("pending beat overwritten");
	a_last_lerp_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LWAIT && stat.l_done && stat.l_last) |=> state_q == ST_OUT)
		else $error("final interpolation did not reach output");
	a_query_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_XRD && !req_ready)) else $error("query not started");
endmodule
